[rtl/srkms_pkg.sv]
`default_nettype none
package srkms_pkg;

  localparam int unsigned RowLevelsWidth = 10;
  localparam int unsigned ColumnIdxWidth = 5;
  localparam int unsigned ColumnCntWidth = 6;
  localparam int unsigned HalfWidth      = 16;
  localparam int unsigned DelayWidth     = 17;
  localparam int unsigned CfgIdxWidth    = 2;
  localparam int unsigned CfgDataWidth   = 16;
  localparam int unsigned InTdataWidth   = 16;
  localparam int unsigned OutTdataWidth  = 24;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SCAN_ENABLE  = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_HALF_PERIOD  = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_DATA    = 8'b0000_0010,
    PH_CLKHI   = 8'b0000_0100,
    PH_LATCH   = 8'b0000_1000,
    PH_RELEASE = 8'b0001_0000,
    PH_PRECLR  = 8'b0010_0000,
    PH_CLRLO   = 8'b0100_0000,
    PH_CLRHI   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic                      scan_enable;
    logic [ColumnCntWidth-1:0] column_count;
    logic [HalfWidth-1:0]      half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic                      data_pin;
    logic                      clock_pin;
    logic                      latch_pin;
    logic                      clear_pin;
    logic                      column_valid;
    logic [ColumnIdxWidth-1:0] column_index;
    logic [RowLevelsWidth-1:0] row_bits;
    logic                      last_column;
  } result_t;

endpackage
`default_nettype wire

[rtl/srkms_cfg.sv]
`default_nettype none
module srkms_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [srkms_pkg::CfgIdxWidth-1:0]    wr_index,
  input  wire logic [srkms_pkg::CfgDataWidth-1:0]   wr_data,
  output srkms_pkg::cfg_t                           cfg
);
  import srkms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_enable       <= 1'b1;
      cfg.column_count      <= ColumnCntWidth'(24);
      cfg.half_period_ticks <= HalfWidth'(20);
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_SCAN_ENABLE:  cfg.scan_enable       <= wr_data[0];
        CFG_COLUMN_COUNT: cfg.column_count      <= wr_data[ColumnCntWidth-1:0];
        CFG_HALF_PERIOD:  cfg.half_period_ticks <= wr_data[HalfWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/srkms_core.sv]
`default_nettype none
module srkms_core #(
  parameter int unsigned ROWS        = 10,
  parameter int unsigned MAX_COLUMNS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   advance,
  input  wire logic [srkms_pkg::RowLevelsWidth-1:0]   row_levels,
  input  srkms_pkg::cfg_t                             cfg,
  output srkms_pkg::result_t                          result
);
  import srkms_pkg::*;

  localparam logic [ColumnCntWidth-1:0] MaxCols = ColumnCntWidth'(MAX_COLUMNS);
  localparam logic [RowLevelsWidth-1:0] RowMask = RowLevelsWidth'((1 << ROWS) - 1);

  phase_t                    phase, phase_next;
  logic [ColumnIdxWidth-1:0] column_counter, column_counter_next;
  logic [ColumnIdxWidth-1:0] bit_counter, bit_counter_next;
  logic [DelayWidth-1:0]     delay_counter, delay_counter_next;
  logic                      data_pin, data_pin_next;
  logic                      clock_pin, clock_pin_next;
  logic                      latch_pin, latch_pin_next;
  logic                      clear_pin, clear_pin_next;

  logic [ColumnCntWidth-1:0] count_eff;
  logic [ColumnIdxWidth-1:0] last_idx;
  logic [DelayWidth-1:0]     half;
  logic [DelayWidth-1:0]     twice_half;
  logic [DelayWidth-1:0]     delay_dec;
  logic [ColumnIdxWidth-1:0] bit_dec;
  logic [ColumnIdxWidth-1:0] column_wrap;
  logic                      at_last;

  assign count_eff  = (cfg.column_count == '0) ? ColumnCntWidth'(1) :
                      (cfg.column_count > MaxCols) ? MaxCols : cfg.column_count;
  assign last_idx   = ColumnIdxWidth'(count_eff - ColumnCntWidth'(1));
  assign half       = (cfg.half_period_ticks == '0) ? DelayWidth'(1) :
                      {1'b0, cfg.half_period_ticks};
  assign twice_half = {half[DelayWidth-2:0], 1'b0};
  assign delay_dec  = (delay_counter != '0) ? delay_counter - DelayWidth'(1) : delay_counter;
  assign bit_dec    = bit_counter - ColumnIdxWidth'(1);
  assign at_last    = column_counter >= last_idx;
  assign column_wrap = at_last ? '0 : column_counter + ColumnIdxWidth'(1);

  always_comb begin
    phase_next          = phase;
    column_counter_next = column_counter;
    bit_counter_next    = bit_counter;
    delay_counter_next  = delay_counter;
    data_pin_next       = data_pin;
    clock_pin_next      = clock_pin;
    latch_pin_next      = latch_pin;
    clear_pin_next      = clear_pin;
    result              = '0;

    if (!cfg.scan_enable) begin
      phase_next          = PH_IDLE;
      column_counter_next = '0;
      bit_counter_next    = '0;
      delay_counter_next  = '0;
      data_pin_next       = 1'b0;
      clock_pin_next      = 1'b0;
      latch_pin_next      = 1'b1;
      clear_pin_next      = 1'b1;
    end else if (phase == PH_IDLE) begin
      column_counter_next = '0;
      bit_counter_next    = last_idx;
      data_pin_next       = (last_idx == '0);
      delay_counter_next  = half;
      phase_next          = PH_DATA;
    end else begin
      delay_counter_next = delay_dec;
      if (delay_dec == '0) begin
        case (phase)
          PH_DATA: begin
            clock_pin_next     = 1'b1;
            delay_counter_next = half;
            phase_next         = PH_CLKHI;
          end
          PH_CLKHI: begin
            clock_pin_next = 1'b0;
            if (bit_counter != '0) begin
              bit_counter_next   = bit_dec;
              data_pin_next      = (column_counter == bit_dec);
              delay_counter_next = half;
              phase_next         = PH_DATA;
            end else begin
              latch_pin_next     = 1'b1;
              delay_counter_next = twice_half;
              phase_next         = PH_LATCH;
            end
          end
          PH_LATCH: begin
            result.column_valid = 1'b1;
            result.column_index = column_counter;
            result.row_bits     = row_levels & RowMask;
            result.last_column  = at_last;
            latch_pin_next      = 1'b0;
            delay_counter_next  = twice_half;
            phase_next          = PH_RELEASE;
          end
          PH_RELEASE: begin
            delay_counter_next = half;
            phase_next         = PH_PRECLR;
          end
          PH_PRECLR: begin
            clear_pin_next     = 1'b0;
            delay_counter_next = half;
            phase_next         = PH_CLRLO;
          end
          PH_CLRLO: begin
            clear_pin_next     = 1'b1;
            delay_counter_next = half;
            phase_next         = PH_CLRHI;
          end
          PH_CLRHI: begin
            column_counter_next = column_wrap;
            bit_counter_next    = last_idx;
            data_pin_next       = (column_wrap == last_idx);
            delay_counter_next  = half;
            phase_next          = PH_DATA;
          end
          default: begin
            phase_next          = PH_IDLE;
            column_counter_next = '0;
            bit_counter_next    = '0;
            delay_counter_next  = '0;
            data_pin_next       = 1'b0;
            clock_pin_next      = 1'b0;
            latch_pin_next      = 1'b1;
            clear_pin_next      = 1'b1;
          end
        endcase
      end
    end

    result.data_pin  = data_pin_next;
    result.clock_pin = clock_pin_next;
    result.latch_pin = latch_pin_next;
    result.clear_pin = clear_pin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      column_counter <= '0;
      bit_counter    <= '0;
      delay_counter  <= '0;
      data_pin       <= 1'b0;
      clock_pin      <= 1'b0;
      latch_pin      <= 1'b1;
      clear_pin      <= 1'b1;
    end else if (advance) begin
      phase          <= phase_next;
      column_counter <= column_counter_next;
      bit_counter    <= bit_counter_next;
      delay_counter  <= delay_counter_next;
      data_pin       <= data_pin_next;
      clock_pin      <= clock_pin_next;
      latch_pin      <= latch_pin_next;
      clear_pin      <= clear_pin_next;
    end
  end

  a_sample_drops_latch: assert property (@(posedge clk) disable iff (rst)
    result.column_valid |-> (!result.latch_pin && phase == PH_LATCH))
    else $error("rows sampled outside the latch phase");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (!data_pin && !clock_pin && latch_pin && clear_pin))
    else $error("pins not at rest while idle");

  a_busy_delay: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (delay_counter != '0))
    else $error("delay counter empty while scanning");

  a_disable_idles: assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg.scan_enable) |=> (phase == PH_IDLE && column_counter == '0))
    else $error("disable did not return the sequencer to idle");

endmodule
`default_nettype wire

[rtl/srkms_out_reg.sv]
`default_nettype none
module srkms_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  srkms_pkg::result_t   in_result,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output srkms_pkg::result_t   out_result
);
  import srkms_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_result <= in_result;
    end
  end

endmodule
`default_nettype wire

[rtl/shift_register_key_matrix_scanner.sv]
`default_nettype none
// Key matrix scanner for a column drive through an external serial shift register. Each input
// item is one time tick carrying the row pin levels; each accepted item yields exactly one result
// item with the data, clock, latch and active-low clear pin levels after that tick, plus, on the
// tick the rows are sampled, the column index, its masked row bits and a last-column flag. An item
// is taken every clock cycle and its result appears in the next cycle from the output register;
// the input side stalls only while that register holds a result not yet taken. Configuration
// writes are accepted at any time and take effect on the next item.
module shift_register_key_matrix_scanner #(
  parameter int unsigned ROWS        = 10,
  parameter int unsigned MAX_COLUMNS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // row_levels[9:0], zero pad
  input  wire logic [srkms_pkg::InTdataWidth-1:0]    s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // data_pin, clock_pin, latch_pin, clear_pin, column_index[4:0], row_bits[9:0], zero pad
  output logic [srkms_pkg::OutTdataWidth-1:0]        m_axis_tdata,
  // column_valid
  output logic                                       m_axis_tuser,
  // last_column
  output logic                                       m_axis_tlast,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [srkms_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire logic [srkms_pkg::CfgDataWidth-1:0]    cfg_data
);
  import srkms_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t held_result;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = s_axis_tvalid && s_axis_tready;

  srkms_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  srkms_core #(
    .ROWS        (ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .row_levels (s_axis_tdata[RowLevelsWidth-1:0]),
    .cfg        (cfg),
    .result     (step_result)
  );

  srkms_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_result  (step_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (held_result)
  );

  assign m_axis_tdata = {5'b0, held_result.row_bits, held_result.column_index,
                         held_result.clear_pin, held_result.latch_pin,
                         held_result.clock_pin, held_result.data_pin};
  assign m_axis_tuser = held_result.column_valid;
  assign m_axis_tlast = held_result.last_column;

endmodule
`default_nettype wire

[test/shift_register_key_matrix_scanner_tb.sv]
`default_nettype none
module shift_register_key_matrix_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srkms_pkg::*;

  localparam int MaxCols = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int DirLen = 28;

  localparam result_t PINS_IDLE = '{data_pin: 1'b0, clock_pin: 1'b0, latch_pin: 1'b1,
                                    clear_pin: 1'b1, column_valid: 1'b0, column_index: '0,
                                    row_bits: '0, last_column: 1'b0};

  typedef struct packed {
    logic                      is_cfg;
    cfg_idx_t                  reg_idx;
    logic [CfgDataWidth-1:0]   wdata;
    logic [RowLevelsWidth-1:0] rows;
    logic                      typed;
    result_t                   want;
  } dir_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutTdataWidth-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxWidth-1:0]   cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  shift_register_key_matrix_scanner u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // scanner copy: configuration
  logic                      cfg_en = 1'b1;
  logic [ColumnCntWidth-1:0] cfg_cols = 6'd24;
  logic [HalfWidth-1:0]      cfg_half = 16'd20;
  // scanner copy: sequencer state
  phase_t                    st_phase = PH_IDLE;
  logic [ColumnIdxWidth-1:0] st_col = '0;
  logic [ColumnIdxWidth-1:0] st_bit = '0;
  logic [DelayWidth-1:0]     st_delay = '0;
  logic                      pin_data = 1'b0;
  logic                      pin_clk = 1'b0;
  logic                      pin_latch = 1'b1;
  logic                      pin_clear = 1'b1;

  result_t     tick_results[$];
  int          errors = 0;
  int          sent = 0;
  int          taken = 0;
  int unsigned cycles = 0;
  bit          tx_eager = 1'b0;
  bit          rx_eager = 1'b0;

  dir_row_t dir_tab [DirLen] = '{
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b1, PINS_IDLE},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h000, 1'b1, PINS_IDLE},
    '{1'b1, CFG_SCAN_ENABLE,  16'h0000, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h155, 1'b1, PINS_IDLE},
    '{1'b1, CFG_COLUMN_COUNT, 16'h0000, 10'h000, 1'b0, '0},
    '{1'b1, CFG_HALF_PERIOD,  16'h0000, 10'h000, 1'b0, '0},
    '{1'b1, CFG_SCAN_ENABLE,  16'h0001, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h2AA, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h155, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h001, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h200, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h155, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h2AA, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h100, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h002, 1'b0, '0},
    '{1'b1, CFG_COLUMN_COUNT, 16'h003F, 10'h000, 1'b0, '0},
    '{1'b1, CFG_HALF_PERIOD,  16'hFFFF, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h3FF, 1'b0, '0},
    '{1'b1, CFG_SCAN_ENABLE,  16'h0000, 10'h000, 1'b0, '0},
    '{1'b0, CFG_UNUSED,       16'h0000, 10'h2AA, 1'b1, PINS_IDLE}
  };

  function automatic int cols_used();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MaxCols) return MaxCols;
    return int'(cfg_cols);
  endfunction

  function automatic int half_used();
    return (cfg_half == 0) ? 1 : int'(cfg_half);
  endfunction

  task automatic park();
    st_phase = PH_IDLE;
    st_col = '0;
    st_bit = '0;
    st_delay = '0;
    pin_data = 1'b0;
    pin_clk = 1'b0;
    pin_latch = 1'b1;
    pin_clear = 1'b1;
  endtask

  task automatic drive_bit();
    pin_data = (st_col == st_bit);
    st_delay = DelayWidth'(half_used());
    st_phase = PH_DATA;
  endtask

  task automatic start_column();
    st_bit = ColumnIdxWidth'(cols_used() - 1);
    drive_bit();
  endtask

  task automatic scan_tick(input logic [RowLevelsWidth-1:0] rows, output result_t r);
    int h;
    h = half_used();
    r = '0;
    if (!cfg_en) begin
      park();
    end else if (st_phase == PH_IDLE) begin
      st_col = '0;
      start_column();
    end else begin
      if (st_delay != 0) st_delay--;
      if (st_delay == 0) begin
        case (st_phase)
          PH_DATA: begin
            pin_clk = 1'b1;
            st_delay = DelayWidth'(h);
            st_phase = PH_CLKHI;
          end
          PH_CLKHI: begin
            pin_clk = 1'b0;
            if (st_bit != 0) begin
              st_bit--;
              drive_bit();
            end else begin
              pin_latch = 1'b1;
              st_delay = DelayWidth'(2 * h);
              st_phase = PH_LATCH;
            end
          end
          PH_LATCH: begin
            r.column_valid = 1'b1;
            r.column_index = st_col;
            r.row_bits = rows;
            r.last_column = (int'(st_col) >= cols_used() - 1);
            pin_latch = 1'b0;
            st_delay = DelayWidth'(2 * h);
            st_phase = PH_RELEASE;
          end
          PH_RELEASE: begin
            st_delay = DelayWidth'(h);
            st_phase = PH_PRECLR;
          end
          PH_PRECLR: begin
            pin_clear = 1'b0;
            st_delay = DelayWidth'(h);
            st_phase = PH_CLRLO;
          end
          PH_CLRLO: begin
            pin_clear = 1'b1;
            st_delay = DelayWidth'(h);
            st_phase = PH_CLRHI;
          end
          PH_CLRHI: begin
            if (int'(st_col) >= cols_used() - 1) st_col = '0;
            else st_col++;
            start_column();
          end
          default: park();
        endcase
      end
    end
    r.data_pin = pin_data;
    r.clock_pin = pin_clk;
    r.latch_pin = pin_latch;
    r.clear_pin = pin_clear;
  endtask

  task automatic flag(input string msg);
    errors++;
    $display("[%0t] result %0d: %s", $time, taken, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic send_tick(input logic [RowLevelsWidth-1:0] rows, input logic typed,
                           input result_t typed_want);
    int gap;
    bit ok;
    result_t want;
    gap = tx_eager ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InTdataWidth - RowLevelsWidth){1'b0}}, rows};
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
    scan_tick(rows, want);
    tick_results.push_back(typed ? typed_want : want);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] wdata);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= wdata;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    case (idx)
      CFG_SCAN_ENABLE:  cfg_en = wdata[0];
      CFG_COLUMN_COUNT: cfg_cols = wdata[ColumnCntWidth-1:0];
      CFG_HALF_PERIOD:  cfg_half = wdata;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input bit en, input logic [ColumnCntWidth-1:0] cols,
                           input logic [HalfWidth-1:0] half, input int n);
    drain();
    cfg_write(CFG_SCAN_ENABLE, {{(CfgDataWidth - 1){1'b0}}, en});
    cfg_write(CFG_COLUMN_COUNT, {{(CfgDataWidth - ColumnCntWidth){1'b0}}, cols});
    cfg_write(CFG_HALF_PERIOD, half);
    tx_eager = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      send_tick(RowLevelsWidth'($urandom_range(0, 1023)), 1'b0, '0);
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int stall;
    bit ok;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_eager = !rx_eager;
      stall = rx_eager ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk);
        ok = m_axis_tvalid;
        @(posedge clk);
      end while (!ok);
    end
  end

  always @(negedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      taken++;
      if (tick_results.size() == 0) begin
        flag("result with nothing outstanding");
      end else begin
        want = tick_results.pop_front();
        check_field("data_pin", int'(m_axis_tdata[0]), int'(want.data_pin));
        check_field("clock_pin", int'(m_axis_tdata[1]), int'(want.clock_pin));
        check_field("latch_pin", int'(m_axis_tdata[2]), int'(want.latch_pin));
        check_field("clear_pin", int'(m_axis_tdata[3]), int'(want.clear_pin));
        check_field("column_index", int'(m_axis_tdata[8:4]), int'(want.column_index));
        check_field("row_bits", int'(m_axis_tdata[18:9]), int'(want.row_bits));
        check_field("column_valid", int'(m_axis_tuser), int'(want.column_valid));
        check_field("last_column", int'(m_axis_tlast), int'(want.last_column));
      end
    end
  end

  bit                        rnd_en;
  logic [ColumnCntWidth-1:0] rnd_cols;
  logic [HalfWidth-1:0]      rnd_half;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirLen; i++) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        send_tick(dir_tab[i].rows, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    run_phase(1'b1, 6'd1, 16'd1, 120);
    run_phase(1'b1, 6'd3, 16'd2, 150);
    run_phase(1'b1, 6'd6, 16'd1, 70);
    run_phase(1'b1, 6'd2, 16'd1, 80);
    run_phase(1'b0, 6'd2, 16'd1, 15);
    run_phase(1'b1, 6'd32, 16'd1, 400);
    run_phase(1'b1, 6'd0, 16'd0, 60);
    run_phase(1'b1, 6'd45, 16'd1, 120);
    run_phase(1'b1, 6'd4, 16'hFFFF, 30);
    run_phase(1'b0, 6'd4, 16'd1, 10);
    run_phase(1'b1, 6'd24, 16'd20, 60);
    run_phase(1'b1, 6'd7, 16'd3, 120);

    while (sent < 1800) begin
      rnd_en = ($urandom_range(0, 9) != 0);
      rnd_cols = ($urandom_range(0, 4) == 0) ? ColumnCntWidth'($urandom_range(0, 63))
                                             : ColumnCntWidth'($urandom_range(1, 8));
      rnd_half = ($urandom_range(0, 9) == 0) ? HalfWidth'($urandom_range(0, 65535))
                                             : HalfWidth'($urandom_range(0, 3));
      run_phase(rnd_en, rnd_cols, rnd_half, $urandom_range(40, 160));
      if (rnd_half > 40) run_phase(1'b0, rnd_cols, 16'd1, 4);
    end

    drain();
    repeat (4) @(posedge clk);
    if (tick_results.size() != 0) flag("results still outstanding at end of run");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
